// ===== hw/rtl/mandelbrot_grid_point_count_core_macros.svh =====
// Assertion macros shared by the mandelbrot grid count RTL.
`ifndef MANDELBROT_GRID_POINT_COUNT_CORE_MACROS_SVH
`define MANDELBROT_GRID_POINT_COUNT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MGC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MGC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/mgc_pkg.sv =====
// Shared types and constants for the mandelbrot grid count block.
package mgc_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = COORD_W - 3;
  localparam int Z_W       = 36;
  localparam int ITER_W    = 16;
  localparam int GRID_W    = 13;
  localparam int MAX_GRID  = 4096;
  localparam int CNT_W     = 25;
  localparam int NUM_CELLS = 4;
  localparam int FLY_W     = $clog2(2 * NUM_CELLS + 1);

  // Register map indexes
  typedef enum logic [2:0] {
    REG_RLO   = 3'd0,
    REG_RHI   = 3'd1,
    REG_ILO   = 3'd2,
    REG_IHI   = 3'd3,
    REG_GRID  = 3'd4,
    REG_ITER  = 3'd5,
    REG_LANE  = 3'd6,
    REG_LANES = 3'd7
  } reg_idx_e;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV_RE = 7'b0000010,
    ST_DIV_IM = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_ORIGIN = 7'b0010000,
    ST_SWEEP  = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

  // One point traveling around the ring
  typedef struct packed {
    logic                      valid;
    logic                      done;
    logic                      in_set;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    logic signed [COORD_W-1:0] zr;
    logic signed [COORD_W-1:0] zi;
    logic [ITER_W-1:0]         iter;
  } token_t;

endpackage

// ===== hw/rtl/mgc_cell.sv =====
// One ring cell: squares z in a first stage, updates and tests it in a second.
module mgc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mgc_pkg::ITER_W-1:0]    limit_i,
  input  mgc_pkg::token_t               tok_i,
  output mgc_pkg::token_t               tok_o
);
  import mgc_pkg::*;

  localparam logic signed [Z_W-1:0] Z_TWO = Z_W'(64'sd1 <<< (FRAC_W + 1));
  localparam logic [64:0] MAG_LIM = 65'd1 << (2 * FRAC_W + 2);

  token_t                 s1_q;
  logic signed [63:0]     rr_q, ii_q, ri_q;
  logic signed [63:0]     zr_x, zi_x;
  token_t                 upd;
  token_t                 tok_q;
  logic [64:0]            mag;
  logic signed [65:0]     dre;
  logic signed [65:0]     nre_w, nim_w;
  logic signed [Z_W-1:0]  nre, nim;

  assign zr_x = 64'(tok_i.zr);
  assign zi_x = 64'(tok_i.zi);

  // Stage 1: products of current z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q <= zr_x * zr_x;
    ii_q <= zi_x * zi_x;
    ri_q <= zr_x * zi_x;
  end

  // Stage 2: magnitude test of z, then next z and its bound test
  assign mag   = {1'b0, rr_q} + {1'b0, ii_q};
  assign dre   = 66'(rr_q) - 66'(ii_q);
  assign nre_w = (dre >>> FRAC_W) + 66'(s1_q.cr);
  assign nim_w = (66'(ri_q) >>> (FRAC_W - 1)) + 66'(s1_q.ci);
  assign nre   = nre_w[Z_W-1:0];
  assign nim   = nim_w[Z_W-1:0];

  always_comb begin
    upd = s1_q;
    if (s1_q.valid && !s1_q.done) begin
      if ((s1_q.iter != '0) && (mag > MAG_LIM)) begin
        upd.done   = 1'b1;
        upd.in_set = 1'b0;
      end else if (s1_q.iter == limit_i) begin
        upd.done   = 1'b1;
        upd.in_set = 1'b1;
      end else begin
        upd.iter = s1_q.iter + 1'b1;
        upd.zr   = nre[COORD_W-1:0];
        upd.zi   = nim[COORD_W-1:0];
        if (nre > Z_TWO || nre < -Z_TWO || nim > Z_TWO || nim < -Z_TWO) begin
          upd.done   = 1'b1;
          upd.in_set = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= upd;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/mgc_div.sv =====
// Bit-serial signed step divider with saturation to the coordinate range.
module mgc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mgc_pkg::COORD_W:0]   dividend_i,
  input  logic [mgc_pkg::GRID_W-1:0]         divisor_i,
  output logic                               done_o,
  output logic signed [mgc_pkg::COORD_W-1:0] quot_o
);
  import mgc_pkg::*;

  localparam int QW  = COORD_W + 1;
  localparam int CW  = $clog2(QW + 1);
  localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (COORD_W - 1)) - 1);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (COORD_W - 1));

  logic              run_q, done_q, neg_q;
  logic [CW-1:0]     cnt_q;
  logic [QW-1:0]     quo_q, neg_quo;
  logic [GRID_W-1:0] rem_q;
  logic [GRID_W:0]   rem_sh;
  logic              fit;

  assign rem_sh = {rem_q, quo_q[QW-1]};
  assign fit    = rem_sh >= {1'b0, divisor_i};

  // One quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[COORD_W];
      quo_q <= dividend_i[COORD_W] ? QW'(-dividend_i) : QW'(dividend_i);
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= fit ? GRID_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[GRID_W-1:0];
      quo_q <= {quo_q[QW-2:0], fit};
    end
  end

  // Sign and saturate the magnitude
  assign neg_quo = -quo_q;
  always_comb begin
    if (!neg_q) begin
      quot_o = (quo_q > POS_LIM) ? POS_LIM[COORD_W-1:0] : quo_q[COORD_W-1:0];
    end else begin
      quot_o = (quo_q > NEG_LIM) ? NEG_LIM[COORD_W-1:0] : neg_quo[COORD_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/mandelbrot_grid_point_count_core.sv =====
// Top level: escape-time inside count over a configured square grid.
//
// A start with go set sweeps every visited grid point and pulses done_o for
// one cycle with inside_count_o; the result cannot be held off. A start with
// go clear does nothing. The two steps come from a bit-serial divider that
// loads and then forms 33 quotient bits; then points circulate in a ring
// of NUM_CELLS cells, two registers per cell, each cell doing one iteration
// per pass, so the ring retires about NUM_CELLS iterations per cycle. Points
// enter at most one per cycle, when the last ring slot is free.
module mandelbrot_grid_point_count_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic                       go_i,
  output logic                       done_o,
  output logic [mgc_pkg::CNT_W-1:0]  inside_count_o
);
  import mgc_pkg::*;
  `include "mandelbrot_grid_point_count_core_macros.svh"

  logic signed [COORD_W-1:0] rlo_q, rhi_q, ilo_q, ihi_q;
  logic [GRID_W-1:0]         grid_q;
  logic [ITER_W-1:0]         iter_q;
  logic [7:0]                lane_q;
  logic [8:0]                lanes_q;
  reg_idx_e                  widx;
  logic                      wr_en;

  state_e                    state_q;
  logic                      done_q;
  logic [CNT_W-1:0]          count_q;
  logic [GRID_W-1:0]         n_q;
  logic [GRID_W-1:0]         n_eff;
  logic [8:0]                lanes_eff;
  logic signed [COORD_W-1:0] rstep_q, istep_q;
  logic signed [40:0]        off_q, stride_q;
  logic signed [COORD_W-1:0] cr_q, ci_q;
  logic [GRID_W-1:0]         col_q, row_q;
  logic [FLY_W-1:0]          fly_q;

  logic                      accept, div_start, div_done;
  logic signed [COORD_W:0]   div_num;
  logic signed [COORD_W-1:0] div_quot;
  logic                      pts_left, ret_free, retire, inject, finish;

  token_t                    ring [NUM_CELLS+1];
  token_t                    entry;

  // Configuration port
  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlo_q   <= 32'shC000_0000;
      rhi_q   <= 32'sh2000_0000;
      ilo_q   <= 32'shE000_0000;
      ihi_q   <= 32'sh2000_0000;
      grid_q  <= GRID_W'(256);
      iter_q  <= ITER_W'(256);
      lane_q  <= 8'd0;
      lanes_q <= 9'd1;
    end else if (wr_en) begin
      case (widx)
        REG_RLO:   rlo_q   <= pwdata;
        REG_RHI:   rhi_q   <= pwdata;
        REG_ILO:   ilo_q   <= pwdata;
        REG_IHI:   ihi_q   <= pwdata;
        REG_GRID:  grid_q  <= pwdata[GRID_W-1:0];
        REG_ITER:  iter_q  <= pwdata[ITER_W-1:0];
        REG_LANE:  lane_q  <= pwdata[7:0];
        REG_LANES: lanes_q <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_RLO:   prdata = rlo_q;
      REG_RHI:   prdata = rhi_q;
      REG_ILO:   prdata = ilo_q;
      REG_IHI:   prdata = ihi_q;
      REG_GRID:  prdata = 32'(grid_q);
      REG_ITER:  prdata = 32'(iter_q);
      REG_LANE:  prdata = 32'(lane_q);
      REG_LANES: prdata = 32'(lanes_q);
      default:   prdata = '0;
    endcase
  end

  // Clamped grid size and stride
  assign n_eff     = (grid_q > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_q;
  assign lanes_eff = (lanes_q == 9'd0) ? 9'd1 : lanes_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Shared step divider
  assign div_start = (accept && go_i && (n_eff != '0)) || (state_q == ST_DIV_RE && div_done);
  assign div_num   = (state_q == ST_DIV_RE) ? ((COORD_W+1)'(ihi_q) - (COORD_W+1)'(ilo_q))
                                            : ((COORD_W+1)'(rhi_q) - (COORD_W+1)'(rlo_q));

  mgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (n_q == '0 ? n_eff : n_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Ring entry: retire finished points, inject new ones
  assign pts_left = (col_q < n_q);
  assign ret_free = !ring[NUM_CELLS].valid || ring[NUM_CELLS].done;
  assign retire   = ring[NUM_CELLS].valid && ring[NUM_CELLS].done;
  assign inject   = (state_q == ST_SWEEP) && pts_left && ret_free;
  assign finish   = (state_q == ST_SWEEP) && !pts_left && (fly_q == '0);

  always_comb begin
    entry = ring[NUM_CELLS];
    if (ret_free) begin
      entry = '0;
      if (inject) begin
        entry.valid = 1'b1;
        entry.cr    = cr_q;
        entry.ci    = ci_q;
        entry.zr    = cr_q;
        entry.zi    = ci_q;
      end
    end
  end

  assign ring[0] = entry;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mgc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .limit_i (iter_q),
      .tok_i   (ring[k]),
      .tok_o   (ring[k+1])
    );
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      n_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
      fly_q   <= '0;
    end else begin
      done_q <= 1'b0;
      fly_q  <= fly_q + FLY_W'(inject) - FLY_W'(retire);
      if (retire && ring[NUM_CELLS].in_set) begin
        count_q <= count_q + 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && go_i) begin
            count_q <= '0;
            n_q     <= n_eff;
            if (n_eff == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= ST_DIV_RE;
            end
          end
        end
        ST_DIV_RE: if (div_done) state_q <= ST_DIV_IM;
        ST_DIV_IM: if (div_done) state_q <= ST_SCALE;
        ST_SCALE:  state_q <= ST_ORIGIN;
        ST_ORIGIN: begin
          col_q   <= GRID_W'(lane_q);
          row_q   <= '0;
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (inject) begin
            if (row_q == n_q - 1'b1) begin
              row_q <= '0;
              col_q <= col_q + GRID_W'(lanes_eff);
            end else begin
              row_q <= row_q + 1'b1;
            end
          end
          if (finish) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Steps and point coordinates
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV_RE && div_done) rstep_q <= div_quot;
    if (state_q == ST_DIV_IM && div_done) istep_q <= div_quot;
    if (state_q == ST_SCALE) begin
      off_q    <= 41'($signed({1'b0, lane_q}) * rstep_q);
      stride_q <= 41'($signed({1'b0, lanes_eff}) * rstep_q);
    end
    if (state_q == ST_ORIGIN) begin
      cr_q <= rlo_q + off_q[COORD_W-1:0];
      ci_q <= ilo_q;
    end else if (inject) begin
      if (row_q == n_q - 1'b1) begin
        cr_q <= cr_q + stride_q[COORD_W-1:0];
        ci_q <= ilo_q;
      end else begin
        ci_q <= ci_q + istep_q;
      end
    end
  end

  assign done_o         = done_q;
  assign inside_count_o = count_q;

  `MGC_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, state_q == ST_IDLE)
  `MGC_ASSERT_IMP(a_fly_bound, clk_i, rst_ni, inject, fly_q <= FLY_W'(2 * NUM_CELLS))
  `MGC_ASSERT_NXT(a_go_starts, clk_i, rst_ni, accept && go_i, busy || done_o)
  `MGC_ASSERT_IMP(a_no_idle_fly, clk_i, rst_ni, state_q == ST_IDLE, fly_q == '0)

endmodule
